FILE: sv/iaidf_pkg.sv
// Shared constants, codes and control types for the indexed array engine.
package iaidf_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 4;
    localparam int LEN_W   = 5;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_FIND   = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_WRITE  = CMD_W'(4);

    localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_RANGE   = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_FULL    = STAT_W'(2);
    localparam logic [STAT_W-1:0] ST_MISSING = STAT_W'(3);

    typedef struct packed {
        logic load;   // capture request beat
        logic exec;   // run command against the array
        logic scan;   // resolve find from match vector
    } t_dp_ctl;

    typedef struct packed {
        logic is_find;
    } t_dp_stat;

endpackage

FILE: sv/iaidf_ctrl.sv
// Controller state machine: sequences capture, execute, find resolve and result beat.
module iaidf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  iaidf_pkg::t_dp_stat i_stat,
    output iaidf_pkg::t_dp_ctl  o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: n_state = i_stat.is_find ? S_SCAN : S_DONE;
            S_SCAN: n_state = S_DONE;
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_DONE);
    assign o_ctl.load = o_ready && i_valid;
    assign o_ctl.exec = (r_state == S_EXEC);
    assign o_ctl.scan = (r_state == S_SCAN);

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("request and result sides open together");

    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> o_ctl.exec)
        else $error("accepted beat not executed next cycle");

    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.scan |=> o_valid)
        else $error("find resolve not followed by result");

endmodule

FILE: sv/iaidf_dp.sv
// Datapath: element cells, count, per-cell shift and compare, result registers.
module iaidf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  iaidf_pkg::t_dp_ctl                     i_ctl,
    output iaidf_pkg::t_dp_stat                    o_stat,
    input  logic        [iaidf_pkg::CMD_W-1:0]     i_cmd,
    input  logic        [iaidf_pkg::POS_W-1:0]     i_position,
    input  logic signed [iaidf_pkg::VALUE_W-1:0]   i_value,
    output logic        [iaidf_pkg::STAT_W-1:0]    o_status,
    output logic signed [iaidf_pkg::VALUE_W-1:0]   o_data,
    output logic        [iaidf_pkg::FOUND_W-1:0]   o_found_position,
    output logic        [iaidf_pkg::LEN_W-1:0]     o_length
);

    localparam int CAP = iaidf_pkg::CAPACITY;
    localparam int DW  = iaidf_pkg::DATA_WIDTH;

    logic [iaidf_pkg::CMD_W-1:0]   r_cmd;
    logic [iaidf_pkg::POS_W-1:0]   r_pos;
    logic [DW-1:0]                 r_word;
    logic [DW-1:0]                 r_cells [CAP];
    logic [iaidf_pkg::CNT_W-1:0]   r_count, n_count;
    logic [CAP-1:0]                r_match, n_match;

    logic [iaidf_pkg::STAT_W-1:0]  r_status, n_status;
    logic [iaidf_pkg::VALUE_W-1:0] r_data, n_data;
    logic [iaidf_pkg::FOUND_W-1:0] r_found, n_found;
    logic [iaidf_pkg::LEN_W-1:0]   r_length;

    logic [DW-1:0]  n_cells [CAP];
    logic [CAP-1:0] cell_we;
    logic           in_range;
    logic           ins_range;
    logic [iaidf_pkg::IDX_W-1:0] pos_idx;
    logic signed [DW-1:0] rd_word;

    assign pos_idx   = iaidf_pkg::IDX_W'(r_pos);
    assign in_range  = (32'(r_pos) < 32'(r_count));
    assign ins_range = (32'(r_pos) <= 32'(r_count));
    assign rd_word   = r_cells[pos_idx];

    always_comb begin
        n_count  = r_count;
        n_status = iaidf_pkg::ST_OK;
        n_data   = '0;
        cell_we  = '0;
        for (int i = 0; i < CAP; i++) begin
            n_cells[i] = r_word;
            n_match[i] = (32'(i) < 32'(r_count)) && (r_cells[i] == r_word);
        end
        unique case (r_cmd)
            iaidf_pkg::CMD_READ: begin
                if (in_range) n_data = iaidf_pkg::VALUE_W'(rd_word);
                else n_status = iaidf_pkg::ST_RANGE;
            end
            iaidf_pkg::CMD_INSERT: begin
                if (!ins_range) begin
                    n_status = iaidf_pkg::ST_RANGE;
                end else if (32'(r_count) >= 32'(CAP)) begin
                    n_status = iaidf_pkg::ST_FULL;
                end else begin
                    for (int i = 1; i < CAP; i++) begin
                        if (32'(i) > 32'(r_pos) && 32'(i) <= 32'(r_count)) begin
                            n_cells[i] = r_cells[i-1];
                            cell_we[i] = 1'b1;
                        end
                    end
                    cell_we[pos_idx] = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            iaidf_pkg::CMD_DELETE: begin
                if (in_range) begin
                    for (int i = 0; i < CAP - 1; i++) begin
                        if (32'(i) >= 32'(r_pos) && 32'(i) + 1 < 32'(r_count)) begin
                            n_cells[i] = r_cells[i+1];
                            cell_we[i] = 1'b1;
                        end
                    end
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = iaidf_pkg::ST_RANGE;
                end
            end
            iaidf_pkg::CMD_FIND: begin
                n_status = iaidf_pkg::ST_MISSING;
            end
            iaidf_pkg::CMD_WRITE: begin
                if (in_range) cell_we[pos_idx] = 1'b1;
                else n_status = iaidf_pkg::ST_RANGE;
            end
            default: ;
        endcase
    end

    // lowest set bit of the match vector
    always_comb begin
        n_found = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (r_match[i]) n_found = iaidf_pkg::FOUND_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_pos  <= i_position;
            r_word <= DW'($unsigned(i_value));
        end
        if (i_ctl.exec) begin
            for (int i = 0; i < CAP; i++) begin
                if (cell_we[i]) r_cells[i] <= n_cells[i];
            end
            r_match  <= n_match;
            r_status <= n_status;
            r_data   <= n_data;
            r_found  <= '0;
            r_length <= iaidf_pkg::LEN_W'(n_count);
        end
        if (i_ctl.scan && (|r_match)) begin
            r_status <= iaidf_pkg::ST_OK;
            r_found  <= n_found;
        end
    end

    assign o_stat.is_find   = (r_cmd == iaidf_pkg::CMD_FIND);
    assign o_status         = r_status;
    assign o_data           = r_data;
    assign o_found_position = r_found;
    assign o_length         = r_length;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAP))
        else $error("element count above capacity");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && r_cmd == iaidf_pkg::CMD_INSERT && n_status == iaidf_pkg::ST_OK)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the array");

    a_find_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && r_cmd == iaidf_pkg::CMD_FIND) |=> $stable(r_count))
        else $error("find changed the element count");

endmodule

FILE: sv/indexed_array_insert_delete_find_core.sv
// Top level of the indexed array engine: controller plus datapath.
//
// Request channel (i_valid / o_ready) carries one command beat: i_cmd, i_position,
// i_value. Commands: read, insert, delete, find, write; unused codes answer ok and
// change nothing. Result channel (o_valid / i_ready) returns one beat per request:
// o_status, o_data, o_found_position, o_length.
// One request is in flight at a time. A captured beat executes in the execute state
// (insert and delete shift every affected cell in that same cycle), and its result
// is offered from the done state. For find, the execute state registers a per-cell
// match vector and a scan state then priority-encodes it before the done state. The
// controller's state loop paces items: a new beat is taken only back in idle.
// o_ready is high only while no request is held; while a result waits on a low
// i_ready, the result registers hold and no new request is taken.
// Reset (synchronous, active low) empties the array and returns to idle; cell
// contents are not cleared, since no entry at or above the length is ever read.
module indexed_array_insert_delete_find_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic        [iaidf_pkg::CMD_W-1:0]     i_cmd,
    input  logic        [iaidf_pkg::POS_W-1:0]     i_position,
    input  logic signed [iaidf_pkg::VALUE_W-1:0]   i_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic        [iaidf_pkg::STAT_W-1:0]    o_status,
    output logic signed [iaidf_pkg::VALUE_W-1:0]   o_data,
    output logic        [iaidf_pkg::FOUND_W-1:0]   o_found_position,
    output logic        [iaidf_pkg::LEN_W-1:0]     o_length
);

    iaidf_pkg::t_dp_ctl  dp_ctl;
    iaidf_pkg::t_dp_stat dp_stat;

    iaidf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_ctl   (dp_ctl)
    );

    iaidf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (dp_ctl),
        .o_stat           (dp_stat),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_status         (o_status),
        .o_data           (o_data),
        .o_found_position (o_found_position),
        .o_length         (o_length)
    );

endmodule

FILE: verif/tb_indexed_array_insert_delete_find_core.sv
// Self-checking testbench for the indexed array engine: directed table, then biased random traffic.
module tb_indexed_array_insert_delete_find_core;
    import iaidf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(5);
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = CMD_W'(7);
    localparam int RAND_ITEMS  = 620;
    localparam int DRAIN_AT    = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int STIM_ROWS   = 19;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] data;
        logic [FOUND_W-1:0] found;
        logic [LEN_W-1:0]   length;
    } t_answer;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        logic               rand_value;
        logic               typed;
        t_answer            want;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [STIM_ROWS] = '{
        '{CMD_READ,        5'd0,  32'd0,        5'd1,  1'b0, 1'b1, '{ST_RANGE,   32'd0, 4'd0, 5'd0}},
        '{CMD_FIND,        5'd0,  32'd0,        5'd1,  1'b0, 1'b1, '{ST_MISSING, 32'd0, 4'd0, 5'd0}},
        '{CMD_DELETE,      5'd0,  32'd0,        5'd1,  1'b0, 1'b1, '{ST_RANGE,   32'd0, 4'd0, 5'd0}},
        '{CMD_INSERT,      5'd1,  32'd5,        5'd1,  1'b0, 1'b1, '{ST_RANGE,   32'd0, 4'd0, 5'd0}},
        '{CMD_SPARE_LAST,  5'd0,  32'd9,        5'd1,  1'b0, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd0}},
        '{CMD_INSERT,      5'd0,  32'h7fffffff, 5'd1,  1'b0, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd1}},
        '{CMD_INSERT,      5'd1,  32'h80000000, 5'd1,  1'b0, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd2}},
        '{CMD_INSERT,      5'd0,  32'hffffffff, 5'd1,  1'b0, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd3}},
        '{CMD_FIND,        5'd0,  32'h7fffffff, 5'd1,  1'b0, 1'b0, '0},
        '{CMD_INSERT,      5'd3,  32'd0,        5'd13, 1'b1, 1'b0, '0},
        '{CMD_INSERT,      5'd16, 32'd0,        5'd1,  1'b0, 1'b1, '{ST_FULL,    32'd0, 4'd0, 5'd16}},
        '{CMD_INSERT,      5'd17, 32'd0,        5'd1,  1'b0, 1'b1, '{ST_RANGE,   32'd0, 4'd0, 5'd16}},
        '{CMD_WRITE,       5'd15, 32'd0,        5'd1,  1'b0, 1'b0, '0},
        '{CMD_FIND,        5'd0,  32'd0,        5'd1,  1'b0, 1'b0, '0},
        '{CMD_DELETE,      5'd0,  32'd0,        5'd1,  1'b0, 1'b0, '0},
        '{CMD_READ,        5'd31, 32'd0,        5'd1,  1'b0, 1'b1, '{ST_RANGE,   32'd0, 4'd0, 5'd15}},
        '{CMD_WRITE,       5'd20, 32'd1,        5'd1,  1'b0, 1'b1, '{ST_RANGE,   32'd0, 4'd0, 5'd15}},
        '{CMD_SPARE_FIRST, 5'd16, 32'd3,        5'd1,  1'b0, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd15}},
        '{CMD_READ,        5'd14, 32'd0,        5'd1,  1'b0, 1'b0, '0}
    };

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                i_ready    = 1'b0;
    logic [CMD_W-1:0]    i_cmd      = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic [VALUE_W-1:0]  i_value    = '0;
    logic                o_ready;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [VALUE_W-1:0]  o_data;
    logic [FOUND_W-1:0]  o_found_position;
    logic [LEN_W-1:0]    o_length;

    logic [VALUE_W-1:0]  shadow_cells [CAPACITY];
    int                  shadow_len;
    t_answer             pending_answers [$];
    int                  mismatches;
    int                  cycle_cnt;
    int                  quiet_left;
    int                  ready_left;

    indexed_array_insert_delete_find_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_data           (o_data),
        .o_found_position (o_found_position),
        .o_length         (o_length)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_answer apply_array_cmd(input logic [CMD_W-1:0] c,
                                                input logic [POS_W-1:0] p,
                                                input logic [VALUE_W-1:0] v);
        t_answer a;
        int      i;
        bit      hit;
        a   = '0;
        hit = 1'b0;
        case (c)
            CMD_READ: begin
                if (p < shadow_len) a.data = shadow_cells[p];
                else a.status = ST_RANGE;
            end
            CMD_INSERT: begin
                if (p > shadow_len) begin
                    a.status = ST_RANGE;
                end else if (shadow_len >= CAPACITY) begin
                    a.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p] = v;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (p < shadow_len) begin
                    for (i = p; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end else begin
                    a.status = ST_RANGE;
                end
            end
            CMD_FIND: begin
                a.status = ST_MISSING;
                for (i = 0; i < shadow_len; i++) begin
                    if (!hit && shadow_cells[i] == v) begin
                        hit      = 1'b1;
                        a.status = ST_OK;
                        a.found  = FOUND_W'(i);
                    end
                end
            end
            CMD_WRITE: begin
                if (p < shadow_len) shadow_cells[p] = v;
                else a.status = ST_RANGE;
            end
            default: ;
        endcase
        a.length = LEN_W'(shadow_len);
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if (r < 3) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic issue_request(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                                 input logic [VALUE_W-1:0] v, input bit typed,
                                 input t_answer want);
        int      gap;
        t_answer predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= c;
        i_position <= p;
        i_value    <= v;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_array_cmd(c, p, v);
        pending_answers.push_back(typed ? want : predicted);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin : ready_gen
        int r;
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                i_ready    <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end else if (r < 40) begin
                i_ready    <= 1'b0;
                ready_left <= $urandom_range(10, 40);
            end else if (r < 55) begin
                i_ready    <= 1'b1;
                ready_left <= $urandom_range(60, 200);
            end else begin
                i_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 7);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d data %h found %0d length %0d",
                             o_status, o_data, o_found_position, o_length);
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status || o_data !== want.data ||
                    o_found_position !== want.found || o_length !== want.length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp status %0d data %h found %0d length %0d, ",
                                  "got status %0d data %h found %0d length %0d"},
                                 want.status, want.data, want.found, want.length,
                                 o_status, o_data, o_found_position, o_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int                 n;
        int                 k;
        int                 r;
        int                 lim;
        bit                 grow;
        logic [CMD_W-1:0]   c;
        logic [POS_W-1:0]   p;
        logic [VALUE_W-1:0] v;
        shadow_len = 0;
        mismatches = 0;
        cycle_cnt  = 0;
        quiet_left = 0;
        ready_left = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < STIM_ROWS; n++) begin
            for (k = 0; k < DIRECTED_ROWS[n].reps; k++) begin
                v = DIRECTED_ROWS[n].rand_value ? VALUE_W'($urandom) : DIRECTED_ROWS[n].value;
                issue_request(DIRECTED_ROWS[n].cmd, DIRECTED_ROWS[n].pos, v,
                              DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
            end
        end

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == DRAIN_AT) begin
                i_valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge i_clk);
            end
            // alternate growing and shrinking phases so both full and empty are reached
            grow = ((n / 80) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < 3) c = CMD_W'(CMD_SPARE_FIRST + $urandom_range(0, 2));
            else if (r < (grow ? 45 : 18)) c = CMD_INSERT;
            else if (r < 60) c = CMD_DELETE;
            else if (r < 75) c = CMD_READ;
            else if (r < 90) c = CMD_FIND;
            else c = CMD_WRITE;

            r   = $urandom_range(0, 99);
            lim = (c == CMD_INSERT) ? shadow_len : shadow_len - 1;
            if (r < 85 && lim >= 0) p = POS_W'($urandom_range(0, lim));
            else if (r < 95) p = POS_W'($urandom_range(shadow_len, CAPACITY + 1));
            else p = POS_W'($urandom_range(0, 31));

            r = $urandom_range(0, 99);
            if (r < 30) begin
                v = VALUE_W'($urandom_range(0, 7));
            end else if (r < 40) begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7fffffff;
                    1: v = 32'h80000000;
                    2: v = '1;
                    default: v = '0;
                endcase
            end else begin
                v = VALUE_W'($urandom);
            end
            if (c == CMD_FIND && shadow_len > 0 && $urandom_range(0, 99) < 60)
                v = shadow_cells[$urandom_range(0, shadow_len - 1)];

            issue_request(c, p, v, 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
